### hw/rtl/icrf_pkg.sv
// ----------------------------------------------------------------------------
// icrf_pkg
// Shared types, constants and helpers of the interrupt controller register
// file: register map, access kinds and priority word geometry.
// ----------------------------------------------------------------------------
package icrf_pkg;

  // number of interrupts served by the bank (1 to 64)
  localparam int unsigned IrqCount  = 48;
  // priority words, four bytes each
  localparam int unsigned PrioWords = (IrqCount + 3) / 4;
  localparam int unsigned PrioIdxW  = (PrioWords > 1) ? $clog2(PrioWords) : 1;

  localparam int unsigned OffW  = 10;
  localparam int unsigned WordW = 32;
  localparam int unsigned ActW  = 64;

  // register map, byte offsets
  localparam logic [OffW-1:0] OffSetEnable  = 10'h000;
  localparam logic [OffW-1:0] OffClrEnable  = 10'h080;
  localparam logic [OffW-1:0] OffSetPending = 10'h100;
  localparam logic [OffW-1:0] OffClrPending = 10'h180;
  localparam logic [OffW-1:0] OffActive     = 10'h200;
  localparam logic [OffW-1:0] OffPrioBase   = 10'h300;
  localparam logic [OffW-1:0] OffPrioEnd    = OffW'(32'h300 + 4 * PrioWords);
  // bits that may be set in an offset of the bit-vector windows
  localparam logic [OffW-1:0] OffMapBits    = 10'h384;
  // bit that picks the upper word of a window
  localparam logic [OffW-1:0] OffHighBit    = 10'h004;

  // access kind of a request
  typedef enum logic {
    ReqRead  = 1'b0,
    ReqWrite = 1'b1
  } req_type_e;

  // target of a request after decode
  typedef enum logic [2:0] {
    TgtNone     = 3'd0,
    TgtSetEn    = 3'd1,
    TgtClrEn    = 3'd2,
    TgtSetPend  = 3'd3,
    TgtClrPend  = 3'd4,
    TgtActive   = 3'd5,
    TgtPrio     = 3'd6
  } target_e;

  // decoded request, passed from the decoder to the bank
  typedef struct packed {
    target_e               target;
    logic                  high;
    logic [PrioIdxW-1:0]   prio_idx;
  } dec_t;

  // byte lanes of a priority word that belong to existing interrupts
  function automatic logic [WordW-1:0] prio_mask(logic [PrioIdxW-1:0] idx);
    logic [WordW-1:0] mask;
    mask = '0;
    for (int unsigned i = 0; i < 4; i++) begin
      if ((int'(idx) * 4 + i) < IrqCount) begin
        mask[8*i +: 8] = 8'hFF;
      end
    end
    return mask;
  endfunction

endpackage

### hw/rtl/icrf_decode.sv
// ----------------------------------------------------------------------------
// icrf_decode
// Offset decoder: maps a byte offset to a register window, the word half
// and the priority word index.
// ----------------------------------------------------------------------------
module icrf_decode (
  input  logic [icrf_pkg::OffW-1:0] offset_i,
  output icrf_pkg::dec_t            dec_o
);
  import icrf_pkg::*;

  logic            prio_hit;
  logic            map_hit;
  logic [OffW-1:0] page;
  logic [OffW-1:0] prio_rel;

  // priority window takes any alignment, other windows need aligned words
  assign prio_hit = (offset_i >= OffPrioBase) && (offset_i < OffPrioEnd);
  assign map_hit  = (offset_i[1:0] == 2'b00) && ((offset_i & ~OffMapBits) == '0);
  assign page     = offset_i & ~OffHighBit;
  assign prio_rel = offset_i - OffPrioBase;

  always_comb begin
    dec_o          = '0;
    dec_o.target   = TgtNone;
    dec_o.high     = offset_i[2];
    dec_o.prio_idx = prio_rel[PrioIdxW+1:2];
    priority if (prio_hit) begin
      dec_o.target = TgtPrio;
    end else if (map_hit) begin
      unique case (page)
        OffSetEnable:  dec_o.target = TgtSetEn;
        OffClrEnable:  dec_o.target = TgtClrEn;
        OffSetPending: dec_o.target = TgtSetPend;
        OffClrPending: dec_o.target = TgtClrPend;
        OffActive:     dec_o.target = TgtActive;
        default:       dec_o.target = TgtNone;
      endcase
    end
  end

endmodule

### hw/rtl/icrf_bank.sv
// ----------------------------------------------------------------------------
// icrf_bank
// Storage of enable, pending and priority state, with write update and
// read selection for one decoded request per cycle.
// ----------------------------------------------------------------------------
module icrf_bank (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_i,
  input  logic                       write_i,
  input  icrf_pkg::dec_t             dec_i,
  input  logic [icrf_pkg::WordW-1:0] write_data_i,
  input  logic [icrf_pkg::ActW-1:0]  active_flags_i,
  output logic [icrf_pkg::WordW-1:0] read_data_o
);
  import icrf_pkg::*;

  logic [IrqCount-1:0] enable_q, enable_d;
  logic [IrqCount-1:0] pending_q, pending_d;
  logic [WordW-1:0]    prio_q [PrioWords];

  logic [2*WordW-1:0]  spread_w;
  logic [IrqCount-1:0] spread;
  logic [2*WordW-1:0]  enable_w, pending_w, active_w;
  logic                do_write;
  logic [WordW-1:0]    prio_wmask;

  // write data placed on the addressed word half
  assign spread_w = dec_i.high ? {write_data_i, {WordW{1'b0}}}
                               : {{WordW{1'b0}}, write_data_i};
  assign spread   = spread_w[IrqCount-1:0];
  assign do_write = req_i && write_i;

  // set and clear updates of the bit vectors
  always_comb begin
    enable_d  = enable_q;
    pending_d = pending_q;
    if (do_write) begin
      unique case (dec_i.target)
        TgtSetEn:   enable_d  = enable_q | spread;
        TgtClrEn:   enable_d  = enable_q & ~spread;
        TgtSetPend: pending_d = pending_q | spread;
        TgtClrPend: pending_d = pending_q & ~spread;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= '0;
      pending_q <= '0;
    end else begin
      enable_q  <= enable_d;
      pending_q <= pending_d;
    end
  end

  // priority words, bytes past the last interrupt stay zero
  assign prio_wmask = prio_mask(dec_i.prio_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned w = 0; w < PrioWords; w++) begin
        prio_q[w] <= '0;
      end
    end else if (do_write && (dec_i.target == TgtPrio)) begin
      prio_q[dec_i.prio_idx] <= write_data_i & prio_wmask;
    end
  end

  // read selection
  assign enable_w  = (2*WordW)'(enable_q);
  assign pending_w = (2*WordW)'(pending_q);
  assign active_w  = active_flags_i & (2*WordW)'({IrqCount{1'b1}});

  always_comb begin
    unique case (dec_i.target)
      TgtSetEn, TgtClrEn:
        read_data_o = dec_i.high ? enable_w[2*WordW-1:WordW] : enable_w[WordW-1:0];
      TgtSetPend, TgtClrPend:
        read_data_o = dec_i.high ? pending_w[2*WordW-1:WordW] : pending_w[WordW-1:0];
      TgtActive:
        read_data_o = dec_i.high ? active_w[2*WordW-1:WordW] : active_w[WordW-1:0];
      TgtPrio:
        read_data_o = prio_q[dec_i.prio_idx];
      default:
        read_data_o = '0;
    endcase
  end

endmodule

### hw/rtl/interrupt_controller_register_file_core.sv
// ----------------------------------------------------------------------------
// interrupt_controller_register_file_core
// Bus side of an interrupt controller register bank: set/clear enable and
// pending windows, a read-only active window and packed priority bytes.
// ----------------------------------------------------------------------------
// A request is taken on any cycle with start_i high; busy_o is never raised,
// so one request per clock is sustained. Each request gives exactly one
// result, passed through an input register, then the decode, state update
// and read mux, then the result register, and shown for one cycle with
// valid_o. The receiver cannot stall. Writes return zero, and a request
// sees all state written by the requests before it.
module interrupt_controller_register_file_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       req_type_i,
  input  logic [icrf_pkg::OffW-1:0]  offset_i,
  input  logic [icrf_pkg::WordW-1:0] write_data_i,
  input  logic [icrf_pkg::ActW-1:0]  active_flags_i,
  output logic                       valid_o,
  output logic [icrf_pkg::WordW-1:0] read_data_o
);
  import icrf_pkg::*;

  logic             req_q;
  logic             write_q;
  logic [OffW-1:0]  offset_q;
  logic [WordW-1:0] wdata_q;
  logic [ActW-1:0]  active_q;
  logic             valid_q;
  logic [WordW-1:0] rdata_q;
  logic [WordW-1:0] bank_rdata;
  dec_t             dec;

  assign busy_o = 1'b0;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= 1'b0;
    end else begin
      req_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      write_q  <= (req_type_i == ReqWrite);
      offset_q <= offset_i;
      wdata_q  <= write_data_i;
      active_q <= active_flags_i;
    end
  end

  icrf_decode u_decode (
    .offset_i (offset_q),
    .dec_o    (dec)
  );

  icrf_bank u_bank (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_q),
    .write_i        (write_q),
    .dec_i          (dec),
    .write_data_i   (wdata_q),
    .active_flags_i (active_q),
    .read_data_o    (bank_rdata)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= req_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_q) begin
      rdata_q <= write_q ? '0 : bank_rdata;
    end
  end

  assign valid_o     = valid_q;
  assign read_data_o = rdata_q;

  // every taken request gives a result through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 valid_o)
    else $error("request taken without a result");

  // no result without an earlier request taken through the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, 2))
    else $error("result without a request");

  // a write always returns zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_q && write_q) |=> (read_data_o == '0))
    else $error("write returned non-zero data");

endmodule
